### rtl/core/pidad_pkg.sv
// Shared types and constants for the averaged-derivative PID block.
// No dependencies.
package pidad_pkg;

   localparam int DataW = 32;
   localparam int CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_INTEG_CLAMP = 3'd3,
      CSR_DRIVE_CLAMP = 3'd4,
      CSR_REVERSE    = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_IE,
      ST_MUL_IT,
      ST_INTEG,
      ST_DIV_D,
      ST_RING,
      ST_SUM,
      ST_DIV_M,
      ST_MUL_P,
      ST_MUL_D,
      ST_OUT,
      ST_RSP
   } state_type;

   function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] mx;
      logic signed [65:0] mn;
      begin
         mx = 66'sd2147483647;
         mn = -66'sd2147483648;
         if (v > mx) sat32 = 32'h7fffffff;
         else if (v < mn) sat32 = 32'h80000000;
         else sat32 = v[DataW-1:0];
      end
   endfunction

   function automatic logic signed [DataW-1:0] clamp_mag(input logic signed [DataW-1:0] v,
                                                         input logic [30:0] lim);
      logic signed [DataW-1:0] l;
      begin
         l = $signed({1'b0, lim});
         if (v > l) clamp_mag = l;
         else if (v < -l) clamp_mag = -l;
         else clamp_mag = v;
      end
   endfunction

endpackage

### rtl/core/pidad_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
// Depends on pidad_pkg.
module pidad_div #(
   parameter int NumW = 64,
   parameter int DenW = 33
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [NumW-1:0] num,
   input  logic signed [DenW-1:0] den,
   output logic                   done,
   output logic signed [NumW-1:0] quo
);
   import pidad_pkg::*;

   localparam int CntW = $clog2(NumW + 1);

   logic [NumW-1:0] q_ff, q_in;
   logic [DenW-1:0] rem_ff, rem_in;
   logic [DenW-1:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [DenW:0] shl;

   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      shl = {rem_ff, q_ff[NumW-1]};
      if (start) begin
         q_in = num[NumW-1] ? NumW'(-num) : NumW'(num);
         d_in = den[DenW-1] ? DenW'(-den) : DenW'(den);
         neg_in = num[NumW-1] ^ den[DenW-1];
         rem_in = '0;
         cnt_in = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shl >= {1'b0, d_ff}) begin
            rem_in = DenW'(shl - {1'b0, d_ff});
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = shl[DenW-1:0];
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done = busy_ff && (cnt_ff == CntW'(1));
   assign quo = neg_ff ? -$signed(q_in) : $signed(q_in);
endmodule

### rtl/core/pid_with_averaged_derivative.sv
// Top level of the averaged-derivative PID controller step.
// Depends on pidad_pkg and pidad_div.
//
// One word in gives one drive word out. A step with a non-positive time step or the first
// valid step goes straight to the response; a full step runs the shared bit-serial divider
// for the derivative and again for the mean, and sums the window entries one at a time.
// The single 32x32 multiplier is used for the four products in turn. req_tready is high
// only while the block is idle.
module pid_with_averaged_derivative #(
   parameter int DERIV_WINDOW = 10,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // measured[31:0], target[63:32], time_step[95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drive[31:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pidad_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import pidad_pkg::*;

   localparam int PosW = (DERIV_WINDOW > 1) ? $clog2(DERIV_WINDOW) : 1;
   localparam int FillW = $clog2(DERIV_WINDOW + 1);
   localparam int SumW = DataW + FillW + 1;

   logic signed [31:0] kp_ff, ki_ff, kd_ff;
   logic [30:0] iclamp_ff, dclamp_ff;
   logic rev_ff;

   state_type st_ff, st_in;
   logic signed [31:0] integ_ff, integ_in, perr_ff, perr_in, err_ff, err_in;
   logic signed [31:0] dt_ff, dt_in, t_ff, t_in, acc_ff, acc_in, drv_ff, drv_in;
   logic primed_ff, primed_in;
   logic signed [31:0] ring_ff [DERIV_WINDOW];
   logic ring_we;
   logic [PosW-1:0] pos_ff, pos_in, idx_ff, idx_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic signed [SumW-1:0] sum_ff, sum_in;

   logic signed [31:0] ma, mb;
   logic signed [63:0] prod;
   logic signed [31:0] mres;

   logic div_start, div_done;
   logic signed [63:0] div_num, div_quo;
   logic signed [32:0] div_den;

   logic signed [31:0] in_meas, in_tgt, in_dt, in_err;

   assign in_meas = req_tdata[31:0];
   assign in_tgt = req_tdata[63:32];
   assign in_dt = req_tdata[95:64];
   assign in_err = sat32(66'(in_tgt) - 66'(in_meas));

   assign prod = ma * mb;
   assign mres = sat32(66'(prod >>> FRAC_BITS));

   pidad_div #(.NumW(64), .DenW(33)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_quo)
   );

   assign csr_ready = 1'b1;
   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_RSP);
   assign rsp_tdata = drv_ff;

   always_comb begin
      st_in = st_ff;
      integ_in = integ_ff;
      perr_in = perr_ff;
      err_in = err_ff;
      dt_in = dt_ff;
      t_in = t_ff;
      acc_in = acc_ff;
      drv_in = drv_ff;
      primed_in = primed_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      fill_in = fill_ff;
      sum_in = sum_ff;
      ring_we = 1'b0;
      div_start = 1'b0;
      div_num = (64'(err_ff) - 64'(perr_ff)) <<< FRAC_BITS;
      div_den = 33'(dt_ff);
      ma = ki_ff;
      mb = err_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               err_in = in_err;
               dt_in = in_dt;
               drv_in = '0;
               if (in_dt <= 0) st_in = ST_RSP;
               else if (!primed_ff) begin
                  perr_in = in_err;
                  primed_in = 1'b1;
                  st_in = ST_RSP;
               end else st_in = ST_MUL_IE;
            end
         end
         ST_MUL_IE: begin
            t_in = mres;
            st_in = ST_MUL_IT;
         end
         ST_MUL_IT: begin
            ma = t_ff;
            mb = dt_ff;
            t_in = mres;
            st_in = ST_INTEG;
         end
         ST_INTEG: begin
            integ_in = clamp_mag(sat32(66'(integ_ff) + 66'(t_ff)), iclamp_ff);
            div_start = 1'b1;
            st_in = ST_DIV_D;
         end
         ST_DIV_D: begin
            if (div_done) begin
               t_in = sat32(66'(div_quo));
               st_in = ST_RING;
            end
         end
         ST_RING: begin
            ring_we = 1'b1;
            pos_in = (32'(pos_ff) == DERIV_WINDOW - 1) ? '0 : pos_ff + 1'b1;
            if (32'(fill_ff) < DERIV_WINDOW) fill_in = fill_ff + 1'b1;
            idx_in = '0;
            sum_in = '0;
            st_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in = sum_ff + SumW'(ring_ff[idx_ff]);
            if (32'(idx_ff) + 1 >= 32'(fill_ff)) begin
               st_in = ST_DIV_M;
               div_start = 1'b1;
               div_num = 64'(sum_in);
               div_den = 33'({1'b0, fill_ff});
            end else idx_in = idx_ff + 1'b1;
         end
         ST_DIV_M: begin
            if (div_done) begin
               t_in = div_quo[31:0];
               st_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            ma = kp_ff;
            mb = err_ff;
            acc_in = mres;
            st_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            ma = kd_ff;
            mb = t_ff;
            t_in = mres;
            st_in = ST_OUT;
         end
         ST_OUT: begin
            drv_in = clamp_mag(sat32(66'(acc_ff) + 66'(integ_ff) + 66'(t_ff)), dclamp_ff);
            if (rev_ff) drv_in = -drv_in;
            perr_in = err_ff;
            st_in = ST_RSP;
         end
         ST_RSP: begin
            if (rsp_tready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         integ_ff <= '0;
         perr_ff <= '0;
         primed_ff <= 1'b0;
         pos_ff <= '0;
         fill_ff <= '0;
         kp_ff <= '0;
         ki_ff <= '0;
         kd_ff <= '0;
         iclamp_ff <= 31'd6553600;
         dclamp_ff <= 31'd3276800;
         rev_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         integ_ff <= integ_in;
         perr_ff <= perr_in;
         primed_ff <= primed_in;
         pos_ff <= pos_in;
         fill_ff <= fill_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_PROP_GAIN:   kp_ff <= csr_data;
               CSR_INTEG_GAIN:  ki_ff <= csr_data;
               CSR_DERIV_GAIN:  kd_ff <= csr_data;
               CSR_INTEG_CLAMP: iclamp_ff <= csr_data[30:0];
               CSR_DRIVE_CLAMP: dclamp_ff <= csr_data[30:0];
               CSR_REVERSE:     rev_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
      err_ff <= err_in;
      dt_ff <= dt_in;
      t_ff <= t_in;
      acc_ff <= acc_in;
      drv_ff <= drv_in;
      idx_ff <= idx_in;
      sum_ff <= sum_in;
   end

   for (genvar g = 0; g < DERIV_WINDOW; g++) begin : g_ring
      always_ff @(posedge clock) begin
         if (reset) ring_ff[g] <= '0;
         else if (ring_we && 32'(pos_ff) == g) ring_ff[g] <= t_ff;
      end
   end
endmodule

### sim/pid_with_averaged_derivative_test.sv
// Self-checking testbench for the averaged-derivative PID step, checked word by word
// against a predictor class. Depends on pidad_pkg and the pid_with_averaged_derivative RTL.
module pid_with_averaged_derivative_test;
   import pidad_pkg::*;

   localparam int FracBits = 16;
   localparam int Window = 10;
   localparam logic [CsrIdxW-1:0] CsrUnusedIdx = 3'd7;
   localparam int WatchdogLimit = 20000;
   localparam int HoldCycles = 600;

   class pid_scoreboard;
      logic signed [31:0] kp, ki, kd;
      logic [30:0] integ_lim, drive_lim;
      logic reverse;
      logic signed [31:0] integ, last_err;
      logic primed;
      logic signed [31:0] ring [Window];
      int ring_wr, ring_cnt;
      logic [31:0] drive_q [$];
      int errors, words_in, words_out, zero_steps, full_steps;

      function new();
         kp = 0; ki = 0; kd = 0;
         integ_lim = 31'd6553600; drive_lim = 31'd3276800; reverse = 0;
         integ = 0; last_err = 0; primed = 0;
         foreach (ring[i]) ring[i] = 0;
         ring_wr = 0; ring_cnt = 0;
         errors = 0; words_in = 0; words_out = 0; zero_steps = 0; full_steps = 0;
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint fmul(longint a, longint b);
         longint p;
         p = a * b;
         return sat(p >>> FracBits);
      endfunction

      function longint clamp(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function void set_reg(logic [CsrIdxW-1:0] idx, logic [31:0] v);
         case (idx)
            CSR_PROP_GAIN: kp = v;
            CSR_INTEG_GAIN: ki = v;
            CSR_DERIV_GAIN: kd = v;
            CSR_INTEG_CLAMP: integ_lim = v[30:0];
            CSR_DRIVE_CLAMP: drive_lim = v[30:0];
            CSR_REVERSE: reverse = v[0];
            default: ;
         endcase
      endfunction

      function void note_input(logic signed [31:0] meas, logic signed [31:0] tgt,
                               logic signed [31:0] dt);
         longint e, d, s, m, r;
         words_in++;
         if (dt <= 0) begin
            drive_q.push_back(32'd0);
            zero_steps++;
            return;
         end
         e = sat(longint'(tgt) - longint'(meas));
         if (!primed) begin
            last_err = e;
            primed = 1;
            drive_q.push_back(32'd0);
            return;
         end
         full_steps++;
         r = sat(longint'(integ) + fmul(fmul(longint'(ki), e), longint'(dt)));
         integ = clamp(r, longint'(integ_lim));
         d = sat(((e - longint'(last_err)) * 65536) / longint'(dt));
         ring[ring_wr] = d;
         ring_wr = (ring_wr + 1) % Window;
         if (ring_cnt < Window) ring_cnt++;
         s = 0;
         for (int i = 0; i < ring_cnt; i++) s += longint'(ring[i]);
         m = s / ring_cnt;
         r = sat(fmul(longint'(kp), e) + longint'(integ) + fmul(longint'(kd), m));
         r = clamp(r, longint'(drive_lim));
         if (reverse) r = -r;
         last_err = e;
         drive_q.push_back(r[31:0]);
      endfunction

      function void check_result(logic [31:0] got);
         logic [31:0] want;
         words_out++;
         if (drive_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected drive word %h", got);
            return;
         end
         want = drive_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("drive mismatch on word %0d: expected %h, got %h",
                        words_out, want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   pid_scoreboard sb;
   bit idle_on;
   bit hold_req;
   int hold_left;
   int quiet_cycles;

   pid_with_averaged_derivative DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // drive receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (hold_req) begin
            hold_req = 0;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(0, 99) < 28);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("pid_with_averaged_derivative_test failed");
         $finish;
      end
   end

   task automatic send_step(logic [31:0] meas, logic [31:0] tgt, logic [31:0] dt);
      while (idle_on && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {dt, tgt, meas};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(meas, tgt, dt);
   endtask

   task automatic stop_sending();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.drive_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_gain();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom();
         default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      endcase
   endfunction

   task automatic config_random();
      write_reg(CSR_PROP_GAIN, rand_gain());
      write_reg(CSR_INTEG_GAIN, rand_gain());
      write_reg(CSR_DERIV_GAIN, rand_gain());
      write_reg(CSR_INTEG_CLAMP, ($urandom_range(0, 3) == 0) ? $urandom()
                                                             : $urandom_range(0, 32'h100_0000));
      write_reg(CSR_DRIVE_CLAMP, ($urandom_range(0, 3) == 0) ? $urandom()
                                                             : $urandom_range(0, 32'h80_0000));
      write_reg(CSR_REVERSE, $urandom());
   endtask

   task automatic send_random(int n);
      logic [31:0] m, t, dt;
      for (int i = 0; i < n; i++) begin
         m = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
         t = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
         dt = $urandom_range(1, 32'h3_0000);
         case ($urandom_range(0, 11))
            0: begin m = $urandom(); t = $urandom(); dt = $urandom(); end
            1: dt = ($urandom_range(0, 1) != 0) ? 32'd0 : ($urandom() | 32'h8000_0000);
            2: dt = $urandom_range(1, 4);
            3: dt = $urandom() & 32'h7fff_ffff;
            default: ;
         endcase
         send_step(m, t, dt);
      end
      stop_sending();
   endtask

   initial begin
      sb = new();
      idle_on = 0;
      hold_req = 0;
      hold_left = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: unit-ish gains, default clamps
      write_reg(CSR_PROP_GAIN, 32'h0001_0000);
      write_reg(CSR_INTEG_GAIN, 32'h0000_8000);
      write_reg(CSR_DERIV_GAIN, 32'h0000_4000);
      write_reg(CsrUnusedIdx, 32'hffff_ffff);
      send_step(32'd0, 32'h0001_0000, 32'd0);
      send_step(32'd0, 32'h0001_0000, 32'h8000_0000);
      send_step(32'd0, 32'h0001_0000, 32'hffff_ffff);
      send_step(32'd0, 32'h0001_0000, 32'h0001_0000);
      send_step(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
      send_step(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
      send_step(32'h0000_0000, 32'h0002_0000, 32'd1);
      send_step(32'h0000_0000, 32'hfffe_0000, 32'h7fff_ffff);
      send_step(32'h0000_0000, 32'h0000_0000, 32'd0);
      for (int i = 0; i < 13; i++)
         send_step(32'h0001_0000 * i, 32'h0010_0000, 32'h0000_4000 + 32'h100 * i);
      stop_sending();
      drain();

      // extremes of the registers, upper bit of the clamps must be dropped
      write_reg(CSR_PROP_GAIN, 32'h7fff_ffff);
      write_reg(CSR_INTEG_GAIN, 32'h8000_0000);
      write_reg(CSR_DERIV_GAIN, 32'h7fff_ffff);
      write_reg(CSR_INTEG_CLAMP, 32'hffff_ffff);
      write_reg(CSR_DRIVE_CLAMP, 32'h7fff_ffff);
      write_reg(CSR_REVERSE, 32'd1);
      send_random(120);
      drain();

      write_reg(CSR_PROP_GAIN, 32'h8000_0000);
      write_reg(CSR_DERIV_GAIN, 32'h8000_0000);
      write_reg(CSR_INTEG_GAIN, 32'h7fff_ffff);
      write_reg(CSR_INTEG_CLAMP, 32'd0);
      write_reg(CSR_DRIVE_CLAMP, 32'd0);
      write_reg(CSR_REVERSE, 32'd0);
      send_random(60);
      drain();

      // random phases, the first without idling, one with a long receiver hold-off
      for (int ph = 0; ph < 6; ph++) begin
         config_random();
         idle_on = (ph != 0);
         if (ph == 2) hold_req = 1;
         send_random(220);
         drain();
      end
      idle_on = 0;

      repeat (20) @(posedge clock);
      $display("covered %0d steps (%0d full, %0d with no time step), %0d drive words checked",
               sb.words_in, sb.full_steps, sb.zero_steps, sb.words_out);
      $display("register sets included gain and clamp extremes and reversed drive");
      if (sb.errors == 0 && sb.drive_q.size() == 0) begin
         $display("pid_with_averaged_derivative_test passed");
      end else begin
         $display("%0d errors, %0d drive words still expected", sb.errors, sb.drive_q.size());
         $display("pid_with_averaged_derivative_test failed");
      end
      $finish;
   end

endmodule
